[design/mbrs_pkg.sv]
// Package with the shared types, constants and helpers of the Modbus register server.
`timescale 1ns / 1ps

package mbrs_pkg;

  // Register table sizes.
  localparam int HOLD_COUNT  = 6;
  localparam int INPUT_COUNT = 12;
  localparam int MAX_COUNT   = (HOLD_COUNT > INPUT_COUNT) ? HOLD_COUNT : INPUT_COUNT;

  localparam int HIDX_W = (HOLD_COUNT > 1) ? $clog2(HOLD_COUNT) : 1;
  localparam int IIDX_W = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  // Frame sizes in bytes.
  localparam int MBAP_BYTES = 6;
  localparam int FRAME_BASE = 9;
  localparam int EXC_BYTES  = 9;
  localparam int ECHO_BYTES = 12;
  localparam int MAX_FRAME  = FRAME_BASE + 2 * MAX_COUNT;
  localparam int CNT_W      = $clog2(MAX_FRAME + 1);

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command and function codes.
  localparam logic       CMD_MODBUS      = 1'b0;
  localparam logic       CMD_LOCAL_LOAD  = 1'b1;
  localparam logic [7:0] FC_READ_HOLD    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  // Exception codes.
  localparam logic [7:0] EXC_FLAG             = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;

  // Job kinds handed from the front to the back.
  localparam logic [2:0] K_LOAD       = 3'd0;
  localparam logic [2:0] K_READ_HOLD  = 3'd1;
  localparam logic [2:0] K_READ_INPUT = 3'd2;
  localparam logic [2:0] K_WRITE      = 3'd3;
  localparam logic [2:0] K_EXC        = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] reg_address;
    logic [15:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       exc_code;
    logic [15:0]      tid;
    logic [7:0]       unit;
    logic [7:0]       fc;
    logic [15:0]      reg_address;
    logic [15:0]      word_value;
    logic [CNT_W-1:0] nbytes;
  } job_t;

  // Reset value of a holding register.
  function automatic logic [15:0] hold_init(input int i);
    logic [15:0] v;
    v = (i < 6) ? 16'(140 + 10 * i) : 16'd0;
    return v;
  endfunction

endpackage

[design/mbrs_front.sv]
// Request classifier: turns an accepted item into a job for the queue or drops it.
`timescale 1ns / 1ps

module mbrs_front
  import mbrs_pkg::*;
(
  input  in_item_t item,
  input  logic     accept,
  output logic     push,
  output job_t     job
);

  logic [16:0] end_sum;
  logic        keep;

  assign end_sum = {1'b0, item.reg_address} + {1'b0, item.word_value};

  always_comb begin
    keep             = 1'b1;
    job.kind         = K_EXC;
    job.exc_code     = EXC_ILLEGAL_FUNCTION;
    job.tid          = item.transaction_id;
    job.unit         = item.unit_id;
    job.fc           = item.func_code;
    job.reg_address  = item.reg_address;
    job.word_value   = item.word_value;
    job.nbytes       = CNT_W'(EXC_BYTES);
    if (item.command == CMD_LOCAL_LOAD) begin
      job.kind = K_LOAD;
      keep     = (item.reg_address < 16'(INPUT_COUNT));
    end else begin
      case (item.func_code)
        FC_READ_HOLD: begin
          if (end_sum > 17'(HOLD_COUNT)) begin
            job.exc_code = (item.reg_address < 16'(HOLD_COUNT)) ?
                           EXC_ILLEGAL_VALUE : EXC_ILLEGAL_ADDRESS;
          end else begin
            job.kind   = K_READ_HOLD;
            job.nbytes = CNT_W'(FRAME_BASE) + CNT_W'({item.word_value, 1'b0});
          end
        end
        FC_READ_INPUT: begin
          if (end_sum > 17'(INPUT_COUNT)) begin
            job.exc_code = (item.reg_address < 16'(INPUT_COUNT)) ?
                           EXC_ILLEGAL_VALUE : EXC_ILLEGAL_ADDRESS;
          end else begin
            job.kind   = K_READ_INPUT;
            job.nbytes = CNT_W'(FRAME_BASE) + CNT_W'({item.word_value, 1'b0});
          end
        end
        FC_WRITE_SINGLE: begin
          if (item.reg_address >= 16'(HOLD_COUNT)) begin
            job.exc_code = EXC_ILLEGAL_ADDRESS;
          end else begin
            job.kind   = K_WRITE;
            job.nbytes = CNT_W'(ECHO_BYTES);
          end
        end
        FC_WRITE_MULTI: begin
          keep = 1'b0;
        end
        default: begin
          job.exc_code = EXC_ILLEGAL_FUNCTION;
        end
      endcase
    end
  end

  assign push = accept && keep;

endmodule

[design/mbrs_queue.sv]
// Short job queue that decouples the classifier from the reply engine.
`timescale 1ns / 1ps

module mbrs_queue
  import mbrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[design/mbrs_back.sv]
// Reply engine: holds the register tables, applies writes and streams reply frames.
`timescale 1ns / 1ps

module mbrs_back
  import mbrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [CNT_W-1:0] POS_TID_HI = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_TID_LO = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_PID_HI = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_PID_LO = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_UNIT   = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_FC     = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_ARG    = CNT_W'(8);
  localparam logic [CNT_W-1:0] POS_DATA   = CNT_W'(FRAME_BASE);
  localparam logic [CNT_W-1:0] POS_ADDR_LO = CNT_W'(9);
  localparam logic [CNT_W-1:0] POS_VAL_HI = CNT_W'(10);

  logic [15:0]      hold_r [HOLD_COUNT];
  logic [15:0]      inp_r  [INPUT_COUNT];
  job_t             cur_r;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic              emit;
  logic              last;
  logic [15:0]       len_field;
  logic [CNT_W-1:0]  dj;
  logic [HIDX_W-1:0] hidx;
  logic [IIDX_W-1:0] iidx;
  logic [15:0]       data_word;
  logic [7:0]        byte_val;

  assign q_pop = !busy_r && !q_empty;
  assign emit  = busy_r && (!out_valid_r || out_ready);
  assign last  = (idx_r == cur_r.nbytes - 1'b1);

  // Register index of the data byte at idx_r: two bytes per register, high first.
  assign dj        = idx_r - POS_DATA;
  assign hidx      = HIDX_W'(cur_r.reg_address) + HIDX_W'(dj[CNT_W-1:1]);
  assign iidx      = IIDX_W'(cur_r.reg_address) + IIDX_W'(dj[CNT_W-1:1]);
  assign data_word = (cur_r.kind == K_READ_HOLD) ? hold_r[hidx] : inp_r[iidx];
  assign len_field = 16'(cur_r.nbytes) - 16'(MBAP_BYTES);

  always_comb begin
    case (idx_r)
      POS_TID_HI: byte_val = cur_r.tid[15:8];
      POS_TID_LO: byte_val = cur_r.tid[7:0];
      POS_PID_HI: byte_val = 8'd0;
      POS_PID_LO: byte_val = 8'd0;
      POS_LEN_HI: byte_val = len_field[15:8];
      POS_LEN_LO: byte_val = len_field[7:0];
      POS_UNIT:   byte_val = cur_r.unit;
      POS_FC:     byte_val = (cur_r.kind == K_EXC) ? (cur_r.fc | EXC_FLAG) : cur_r.fc;
      POS_ARG: begin
        if (cur_r.kind == K_EXC) begin
          byte_val = cur_r.exc_code;
        end else if (cur_r.kind == K_WRITE) begin
          byte_val = cur_r.reg_address[15:8];
        end else begin
          byte_val = {cur_r.word_value[6:0], 1'b0};
        end
      end
      default: begin
        if (cur_r.kind == K_WRITE) begin
          if (idx_r == POS_ADDR_LO) begin
            byte_val = cur_r.reg_address[7:0];
          end else if (idx_r == POS_VAL_HI) begin
            byte_val = cur_r.word_value[15:8];
          end else begin
            byte_val = cur_r.word_value[7:0];
          end
        end else begin
          byte_val = dj[0] ? data_word[7:0] : data_word[15:8];
        end
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      idx_nxt  = '0;
      busy_nxt = (q_job.kind != K_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
    if (emit) begin
      out_data_r.reply_byte <= byte_val;
      out_data_r.last_byte  <= last;
    end
  end

  // Register tables; writes take effect when the job leaves the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HOLD_COUNT; i++) begin
        hold_r[i] <= hold_init(i);
      end
      for (int i = 0; i < INPUT_COUNT; i++) begin
        inp_r[i] <= 16'd0;
      end
    end else if (q_pop) begin
      if (q_job.kind == K_WRITE) begin
        hold_r[HIDX_W'(q_job.reg_address)] <= q_job.word_value;
      end else if (q_job.kind == K_LOAD) begin
        inp_r[IIDX_W'(q_job.reg_address)] <= q_job.word_value;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_busy_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.kind != K_LOAD))
    else $error("local load job entered the send phase");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.nbytes))
    else $error("byte index ran past the frame");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> !busy_r)
    else $error("engine stayed busy after the last byte");
`endif

endmodule

[design/modbus_tcp_register_server.sv]
// Top level of the Modbus TCP register server: classifier, job queue and reply engine.
// Path of a request: job queue, then the reply engine when idle, then its registered reply byte.
// Throughput: one reply byte per cycle while out_ready is high; a frame is 9 to 33 bytes long;
// a local load is applied by the reply engine and produces no reply.
// The two-entry job queue takes new requests while a reply is still streaming.
// Reset (rst_n low, synchronous): queue empty, engine idle, holding registers 140..190,
// input registers zero.
`timescale 1ns / 1ps

module modbus_tcp_register_server
  import mbrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full, q_empty, q_push, q_pop;
  job_t f_job, q_job;

  // No transfer is taken while reset is held.
  assign in_ready = rst_n && !q_full;

  mbrs_front u_front (
    .item   (in_data),
    .accept (in_valid && in_ready),
    .push   (q_push),
    .job    (f_job)
  );

  mbrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  mbrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/tb_modbus_tcp_register_server.sv]
// Self-checking testbench for the Modbus TCP register server: directed and random requests.
`timescale 1ns / 1ps

module tb_modbus_tcp_register_server
  import mbrs_pkg::*;
();

  localparam int CLK_NS       = 10;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_CYCLES = 300;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Shadow copy of the register file, updated in transfer order.
  logic [15:0] hold_shadow [HOLD_COUNT];
  logic [15:0] input_shadow [INPUT_COUNT];

  out_item_t   reply_bytes_q [$];
  logic [7:0]  frame_bytes [$];

  int errors      = 0;
  int idle_pct    = 37;
  int rx_hold_len = 0;

  modbus_tcp_register_server uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_NS / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_modbus_tcp_register_server: FAIL");
    $finish;
  end

  task automatic put_header(logic [15:0] tid, logic [15:0] len, logic [7:0] unit);
    frame_bytes.push_back(tid[15:8]);
    frame_bytes.push_back(tid[7:0]);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(unit);
  endtask

  task automatic put_exception(in_item_t it, logic [7:0] code);
    put_header(it.transaction_id, 16'd3, it.unit_id);
    frame_bytes.push_back(it.func_code | EXC_FLAG);
    frame_bytes.push_back(code);
  endtask

  task automatic put_read(in_item_t it, bit from_input);
    int          size;
    logic [16:0] range_end;
    logic [15:0] word;
    size = from_input ? INPUT_COUNT : HOLD_COUNT;
    // The end of the range is a 17-bit sum, so a wrapped range never looks valid.
    range_end = {1'b0, it.reg_address} + {1'b0, it.word_value};
    if (range_end > 17'(size)) begin
      if (int'(it.reg_address) < size) put_exception(it, EXC_ILLEGAL_VALUE);
      else put_exception(it, EXC_ILLEGAL_ADDRESS);
    end else begin
      put_header(it.transaction_id, 16'(3 + 2 * int'(it.word_value)), it.unit_id);
      frame_bytes.push_back(it.func_code);
      frame_bytes.push_back(8'(2 * int'(it.word_value)));
      for (int i = 0; i < int'(it.word_value); i++) begin
        if (from_input) word = input_shadow[int'(it.reg_address) + i];
        else word = hold_shadow[int'(it.reg_address) + i];
        frame_bytes.push_back(word[15:8]);
        frame_bytes.push_back(word[7:0]);
      end
    end
  endtask

  task automatic predict_reply(in_item_t it);
    out_item_t b;
    frame_bytes.delete();
    if (it.command == CMD_LOCAL_LOAD) begin
      if (int'(it.reg_address) < INPUT_COUNT) input_shadow[int'(it.reg_address)] = it.word_value;
    end else begin
      case (it.func_code)
        FC_READ_HOLD:  put_read(it, 1'b0);
        FC_READ_INPUT: put_read(it, 1'b1);
        FC_WRITE_SINGLE: begin
          if (int'(it.reg_address) >= HOLD_COUNT) begin
            put_exception(it, EXC_ILLEGAL_ADDRESS);
          end else begin
            hold_shadow[int'(it.reg_address)] = it.word_value;
            put_header(it.transaction_id, 16'd6, it.unit_id);
            frame_bytes.push_back(it.func_code);
            frame_bytes.push_back(it.reg_address[15:8]);
            frame_bytes.push_back(it.reg_address[7:0]);
            frame_bytes.push_back(it.word_value[15:8]);
            frame_bytes.push_back(it.word_value[7:0]);
          end
        end
        FC_WRITE_MULTI: ;
        default: put_exception(it, EXC_ILLEGAL_FUNCTION);
      endcase
    end
    foreach (frame_bytes[i]) begin
      b.reply_byte = frame_bytes[i];
      b.last_byte  = (i == frame_bytes.size() - 1);
      reply_bytes_q.push_back(b);
    end
  endtask

  function automatic in_item_t make_request(logic cmd, logic [15:0] tid, logic [7:0] unit,
                                            logic [7:0] fc, logic [15:0] addr,
                                            logic [15:0] val);
    in_item_t it;
    it.command        = cmd;
    it.transaction_id = tid;
    it.unit_id        = unit;
    it.func_code      = fc;
    it.reg_address    = addr;
    it.word_value     = val;
    return it;
  endfunction

  function automatic in_item_t random_request();
    int          pick;
    int          size;
    int          start;
    int          shape;
    logic [15:0] qty;
    logic [7:0]  fc;
    logic [15:0] tid;
    logic [7:0]  unit;
    pick = $urandom_range(0, 99);
    tid  = 16'($urandom);
    unit = 8'($urandom);
    if (pick < 48) begin
      fc    = (pick < 24) ? FC_READ_HOLD : FC_READ_INPUT;
      size  = (pick < 24) ? HOLD_COUNT : INPUT_COUNT;
      start = $urandom_range(0, size);
      shape = $urandom_range(0, 9);
      if (shape == 0) qty = 16'($urandom);
      else if (shape == 1) qty = 16'(size - start + 1);
      else qty = 16'($urandom_range(0, size - start));
      return make_request(CMD_MODBUS, tid, unit, fc, 16'(start), qty);
    end else if (pick < 66) begin
      return make_request(CMD_MODBUS, tid, unit, FC_WRITE_SINGLE,
                          ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, HOLD_COUNT - 1)),
                          16'($urandom));
    end else if (pick < 80) begin
      return make_request(CMD_LOCAL_LOAD, tid, unit, 8'($urandom),
                          ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, INPUT_COUNT - 1)),
                          16'($urandom));
    end else if (pick < 84) begin
      return make_request(CMD_MODBUS, tid, unit, FC_WRITE_MULTI, 16'($urandom), 16'($urandom));
    end
    return make_request(1'($urandom), tid, unit, 8'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Valid stays high after a transfer until the next call either lowers it or presents new data.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_reply(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_local_load();
    send_item(make_request(CMD_LOCAL_LOAD, 16'hFFFF, 8'hFF, 8'h00, 16'd0, 16'hFFFF));
    send_item(make_request(CMD_LOCAL_LOAD, 16'h0000, 8'h00, 8'hFF, 16'(INPUT_COUNT - 1),
                           16'h8001));
    // Loads past the end of the input table are dropped.
    send_item(make_request(CMD_LOCAL_LOAD, 16'h1234, 8'h5A, FC_READ_HOLD, 16'(INPUT_COUNT),
                           16'hA5A5));
    send_item(make_request(CMD_LOCAL_LOAD, 16'h4321, 8'hA5, FC_WRITE_SINGLE, 16'hFFFF,
                           16'h5A5A));
    wait_drained();
  endtask

  task automatic test_read_ranges();
    send_item(make_request(CMD_MODBUS, 16'hFFFF, 8'hFF, FC_READ_INPUT, 16'd0,
                           16'(INPUT_COUNT)));
    send_item(make_request(CMD_MODBUS, 16'h0000, 8'h00, FC_READ_HOLD, 16'd0, 16'(HOLD_COUNT)));
    send_item(make_request(CMD_MODBUS, 16'h0101, 8'h11, FC_READ_HOLD, 16'(HOLD_COUNT), 16'd0));
    send_item(make_request(CMD_MODBUS, 16'h0202, 8'h22, FC_READ_INPUT, 16'(INPUT_COUNT),
                           16'd0));
    send_item(make_request(CMD_MODBUS, 16'h0303, 8'h33, FC_READ_HOLD, 16'(HOLD_COUNT - 1),
                           16'd2));
    send_item(make_request(CMD_MODBUS, 16'h0404, 8'h44, FC_READ_HOLD, 16'(HOLD_COUNT), 16'd1));
    // Start and quantity both at the top: the 17-bit end must not wrap into the table.
    send_item(make_request(CMD_MODBUS, 16'h0505, 8'h55, FC_READ_INPUT, 16'hFFFF, 16'hFFFF));
    send_item(make_request(CMD_MODBUS, 16'h0606, 8'h66, FC_READ_HOLD, 16'd0, 16'hFFFF));
    wait_drained();
  endtask

  task automatic test_write_single();
    send_item(make_request(CMD_MODBUS, 16'hFFFF, 8'hFF, FC_WRITE_SINGLE, 16'd0, 16'hFFFF));
    send_item(make_request(CMD_MODBUS, 16'h0000, 8'h00, FC_WRITE_SINGLE, 16'(HOLD_COUNT - 1),
                           16'h0000));
    send_item(make_request(CMD_MODBUS, 16'h0707, 8'h77, FC_WRITE_SINGLE, 16'(HOLD_COUNT),
                           16'h1234));
    send_item(make_request(CMD_MODBUS, 16'h0808, 8'h88, FC_WRITE_SINGLE, 16'hFFFF, 16'h4321));
    send_item(make_request(CMD_MODBUS, 16'h0909, 8'h99, FC_READ_HOLD, 16'd0, 16'(HOLD_COUNT)));
    wait_drained();
  endtask

  task automatic test_other_functions();
    send_item(make_request(CMD_MODBUS, 16'h0A0A, 8'hAA, FC_WRITE_MULTI, 16'd0, 16'd1));
    send_item(make_request(CMD_MODBUS, 16'h0B0B, 8'hBB, 8'h00, 16'd0, 16'd0));
    send_item(make_request(CMD_MODBUS, 16'h0C0C, 8'hCC, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_request(CMD_MODBUS, 16'h0D0D, 8'hDD, FC_READ_HOLD | EXC_FLAG, 16'd0, 16'd1));
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, int pct);
    idle_pct = pct;
    repeat (count) send_item(random_request());
    wait_drained();
    idle_pct = 37;
  endtask

  // The receiver stops for a long stretch while full-size reads keep coming,
  // so the job queue fills and the input side has to stall.
  task automatic test_backpressure();
    idle_pct    = 0;
    rx_hold_len = STALL_CYCLES;
    repeat (20) begin
      send_item(make_request(CMD_MODBUS, 16'($urandom), 8'($urandom), FC_READ_INPUT, 16'd0,
                             16'(INPUT_COUNT)));
    end
    wait_drained();
    idle_pct = 37;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len - 1) @(negedge clk);
        rx_hold_len = 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_bytes_q.size() == 0) begin
        $error("reply byte %02h transferred with no reply pending", out_data.reply_byte);
        errors++;
      end else begin
        want = reply_bytes_q.pop_front();
        if (out_data.reply_byte !== want.reply_byte) begin
          $error("reply_byte: expected %02h, actual %02h", want.reply_byte, out_data.reply_byte);
          errors++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte, out_data.last_byte);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < HOLD_COUNT; i++) hold_shadow[i] = 16'(140 + 10 * i);
    for (int i = 0; i < INPUT_COUNT; i++) input_shadow[i] = 16'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_local_load();
    test_read_ranges();
    test_write_single();
    test_other_functions();
    test_random_traffic(150, 37);
    // Long stretch with neither side idling.
    test_random_traffic(80, 0);
    test_backpressure();
    test_random_traffic(110, 37);

    if (errors == 0) begin
      $display("tb_modbus_tcp_register_server: PASS");
    end else begin
      $display("tb_modbus_tcp_register_server: FAIL");
    end
    $finish;
  end

endmodule
